// ===== rtl/kfi_pkg.sv =====
// ----------------------------------------------------------------------------
// kfi_pkg: keyframe envelope interpolator shared definitions
// Table geometry, field widths, request and status codes, saturation helper.
// ----------------------------------------------------------------------------
package kfi_pkg;

  localparam int MAX_KEYFRAMES = 16;
  localparam int KF_AW    = $clog2(MAX_KEYFRAMES);
  localparam int KF_CNT_W = $clog2(MAX_KEYFRAMES + 1);

  localparam int POS_W  = 17;
  localparam int LVL_W  = 16;
  localparam int CFG_W  = 5;
  localparam int ENT_W  = POS_W + LVL_W;
  localparam logic [POS_W-1:0] ONE_Q16 = 17'd65536;

  // wide datapath words
  localparam int NUM_W  = 56;
  localparam int DEN_W  = 35;
  localparam int QUOT_W = 18;
  localparam int QBITS  = QUOT_W - 1;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_INTERP = 2'd1;
  localparam logic [1:0] REQ_AVG    = 2'd2;

  localparam logic [1:0] ST_VALID  = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  function automatic logic signed [LVL_W-1:0] sat16(input logic signed [NUM_W-1:0] v);
    logic signed [LVL_W-1:0] r;
    if (v > 56'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -56'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/kfi_ram.sv =====
// ----------------------------------------------------------------------------
// kfi_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kfi_div.sv =====
// ----------------------------------------------------------------------------
// kfi_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero and
// saturates the quotient magnitude at 2^17-1.
// ----------------------------------------------------------------------------
module kfi_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [kfi_pkg::NUM_W-1:0]    num_i,
  input  logic        [kfi_pkg::DEN_W-1:0]    den_i,
  output logic                                done_o,
  output logic signed [kfi_pkg::QUOT_W-1:0]   quot_o
);
  import kfi_pkg::*;

  logic                busy_q, done_q, neg_q, ovf_q;
  logic [4:0]          cnt_q;
  logic [NUM_W-1:0]    rem_q, dsh_q;
  logic [QBITS-1:0]    qmag_q;
  logic                ge;
  logic [QUOT_W-1:0]   mag;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QBITS + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[NUM_W-1];
      rem_q  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      dsh_q  <= NUM_W'({den_i, {QBITS{1'b0}}});
      qmag_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      // first step only checks the quotient range
      if (cnt_q == 5'(QBITS + 1)) begin
        ovf_q <= ge;
      end else begin
        qmag_q <= {qmag_q[QBITS-2:0], ge};
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign mag    = ovf_q ? {1'b0, {QBITS{1'b1}}} : {1'b0, qmag_q};
  assign quot_o = neg_q ? -$signed(mag) : $signed(mag);
  assign done_o = done_q;

endmodule

// ===== rtl/keyframe_envelope_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_envelope_interpolator: piecewise linear envelope over a keyframe table
// Loads store keyframes, interpolate and average queries walk the table; other codes are rejected.
// ----------------------------------------------------------------------------
// Loads and rejects go straight to the result register. An interpolate query
// either holds an end level or walks the table, multiplies and divides. An
// average query either holds the first level or walks the table, then uses
// the shared multiplier for a segment end or the tail, then the bit-serial
// divider. One item in flight. Reset clears control and sets the keyframe
// count to one.
// ----------------------------------------------------------------------------
module keyframe_envelope_interpolator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: keyframe_count
  input  logic                      cfg_we_i,
  input  logic [kfi_pkg::CFG_W-1:0] cfg_wdata_i,
  // request stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // key_index[3:0], key_percent[20:4], key_value[36:21], query_percent[53:37]
  input  logic [55:0]               s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]                s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // result_value[15:0]
  output logic [15:0]               m_axis_tdata,
  // status[1:0]
  output logic [1:0]                m_axis_tuser
);
  import kfi_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE = (22'd1 << 0),  S_OUT = (22'd1 << 1),  S_E0 = (22'd1 << 2),
    S_EL   = (22'd1 << 3),  S_IW  = (22'd1 << 4),  S_IM = (22'd1 << 5),
    S_I2   = (22'd1 << 6),  S_A0  = (22'd1 << 7),  S_AW = (22'd1 << 8),
    S_AA   = (22'd1 << 9),  S_T1  = (22'd1 << 10), S_S1 = (22'd1 << 11),
    S_S2   = (22'd1 << 12), S_S3  = (22'd1 << 13), S_S4 = (22'd1 << 14),
    S_S5   = (22'd1 << 15), S_S6  = (22'd1 << 16), S_S7 = (22'd1 << 17),
    S_S8   = (22'd1 << 18), S_S9  = (22'd1 << 19), S_DS = (22'd1 << 20),
    S_DW   = (22'd1 << 21)
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]         cfg_q;
  logic [KF_CNT_W-1:0]      n_use, n_q, n_d, i_q, i_d;
  logic [1:0]               req_q, req_d;
  logic [POS_W-1:0]         q_q, q_d, pl_q, pl_d, pc_q, pc_d;
  logic signed [LVL_W-1:0]  vl_q, vl_d, vc_q, vc_d;
  logic signed [NUM_W-1:0]  acc_q, acc_d, t_q, t_d, y_q, y_d;
  logic [DEN_W-1:0]         den_q, den_d;
  logic signed [LVL_W-1:0]  res_q, res_d;
  logic [1:0]               st_q, st_d;
  logic                     m_valid_q, m_valid_d;
  logic [15:0]              m_data_q, m_data_d;
  logic [1:0]               m_user_q, m_user_d;

  // request fields
  logic [3:0]               in_idx;
  logic [POS_W-1:0]         in_kp, in_q;
  logic [LVL_W-1:0]         in_kv;
  logic                     s_fire;

  // table RAM
  logic                     ram_we;
  logic [KF_AW-1:0]         rd_addr;
  logic [ENT_W-1:0]         rdata;
  logic [POS_W-1:0]         rd_pos;
  logic signed [LVL_W-1:0]  rd_lvl;

  // shared multiplier
  logic signed [24:0]       ma;
  logic signed [17:0]       mb;
  logic signed [42:0]       prod_q;
  logic signed [NUM_W-1:0]  prod_w;
  logic signed [17:0]       x, run, dv;

  // divider
  logic                     div_start, div_done;
  logic signed [QUOT_W-1:0] quot;

  assign in_idx = s_axis_tdata[3:0];
  assign in_kp  = (s_axis_tdata[20:4] > ONE_Q16) ? ONE_Q16 : s_axis_tdata[20:4];
  assign in_kv  = s_axis_tdata[36:21];
  assign in_q   = (s_axis_tdata[53:37] > ONE_Q16) ? ONE_Q16 : s_axis_tdata[53:37];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // count of zero acts as one, above the table size acts as the table size
  assign n_use = (cfg_q == '0) ? KF_CNT_W'(1) :
                 ((32'(cfg_q) > MAX_KEYFRAMES) ? KF_CNT_W'(MAX_KEYFRAMES)
                                               : KF_CNT_W'(cfg_q));

  assign rd_pos = rdata[POS_W-1:0];
  assign rd_lvl = $signed(rdata[ENT_W-1:POS_W]);

  assign x      = $signed({1'b0, q_q}) - $signed({1'b0, pl_q});
  assign run    = $signed({1'b0, pc_q}) - $signed({1'b0, pl_q});
  assign dv     = 18'(vc_q) - 18'(vl_q);
  assign prod_w = NUM_W'(prod_q);

  kfi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_KEYFRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_idx[KF_AW-1:0]),
    .wdata_i ({in_kv, in_kp}),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  kfi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    req_d     = req_q;
    q_d       = q_q;
    pl_d      = pl_q;
    vl_d      = vl_q;
    pc_d      = pc_q;
    vc_d      = vc_q;
    acc_d     = acc_q;
    t_d       = t_q;
    y_d       = y_q;
    den_d     = den_q;
    res_d     = res_q;
    st_d      = st_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    ram_we    = 1'b0;
    rd_addr   = i_q[KF_AW-1:0];
    ma        = '0;
    mb        = '0;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        if (s_fire) begin
          req_d = s_axis_tuser;
          q_d   = in_q;
          n_d   = n_use;
          res_d = '0;
          st_d  = ST_REJECT;
          state_d = S_OUT;
          case (s_axis_tuser)
            REQ_LOAD: begin
              if (32'(in_idx) < MAX_KEYFRAMES) begin
                ram_we = 1'b1;
                st_d   = ST_STORED;
              end
            end
            REQ_INTERP: state_d = S_E0;
            REQ_AVG: begin
              if (n_use >= KF_CNT_W'(2)) begin
                state_d = S_E0;
              end
            end
            default: ;
          endcase
        end
      end
      S_E0: begin
        pl_d = rd_pos;
        vl_d = rd_lvl;
        if (req_q == REQ_INTERP) begin
          if (n_q == KF_CNT_W'(1) || q_q <= rd_pos) begin
            res_d = rd_lvl;
            st_d  = ST_VALID;
            state_d = S_OUT;
          end else begin
            rd_addr = KF_AW'(n_q - KF_CNT_W'(1));
            state_d = S_EL;
          end
        end else if (q_q <= rd_pos) begin
          res_d = rd_lvl;
          st_d  = ST_VALID;
          state_d = S_OUT;
        end else begin
          // doubled area before the first keyframe
          ma = 25'(rd_lvl);
          mb = $signed({1'b0, rd_pos});
          i_d = KF_CNT_W'(1);
          rd_addr = KF_AW'(1);
          state_d = S_A0;
        end
      end
      S_EL: begin
        if (q_q >= rd_pos) begin
          res_d = rd_lvl;
          st_d  = ST_VALID;
          state_d = S_OUT;
        end else begin
          i_d = KF_CNT_W'(1);
          rd_addr = KF_AW'(1);
          state_d = S_IW;
        end
      end
      S_IW: begin
        if (i_q == n_q - KF_CNT_W'(1) || q_q < rd_pos) begin
          pc_d = rd_pos;
          vc_d = rd_lvl;
          state_d = S_IM;
        end else begin
          pl_d = rd_pos;
          vl_d = rd_lvl;
          i_d  = i_q + KF_CNT_W'(1);
          rd_addr = KF_AW'(i_q + KF_CNT_W'(1));
        end
      end
      S_IM: begin
        ma = 25'(x);
        mb = dv;
        state_d = S_I2;
      end
      S_I2: begin
        acc_d = prod_w;
        den_d = DEN_W'(run[POS_W-1:0]);
        state_d = S_DS;
      end
      S_A0: begin
        acc_d = prod_w <<< 1;
        state_d = S_AW;
      end
      S_AW: begin
        if (i_q < n_q && rd_pos < q_q) begin
          // full trapezoid of one segment
          ma = 25'($signed({1'b0, rd_pos}) - $signed({1'b0, pl_q}));
          mb = 18'(rd_lvl) + 18'(vl_q);
          pl_d = rd_pos;
          vl_d = rd_lvl;
          i_d  = i_q + KF_CNT_W'(1);
          rd_addr = KF_AW'(i_q + KF_CNT_W'(1));
          state_d = S_AA;
        end else if (i_q < n_q) begin
          pc_d = rd_pos;
          vc_d = rd_lvl;
          state_d = S_S1;
        end else begin
          // last level held up to the query
          ma = 25'(x);
          mb = 18'(vl_q);
          state_d = S_T1;
        end
      end
      S_AA: begin
        acc_d = acc_q + prod_w;
        state_d = S_AW;
      end
      S_T1: begin
        acc_d = acc_q + (prod_w <<< 1);
        den_d = DEN_W'({q_q, 1'b0});
        state_d = S_DS;
      end
      S_S1: begin
        ma = 25'(vl_q);
        mb = run;
        state_d = S_S2;
      end
      S_S2: begin
        t_d = prod_w <<< 1;
        ma = 25'(x);
        mb = dv;
        state_d = S_S3;
      end
      S_S3: begin
        t_d = t_q + prod_w;
        state_d = S_S4;
      end
      S_S4: begin
        ma = $signed({5'b0, t_q[19:0]});
        mb = x;
        state_d = S_S5;
      end
      S_S5: begin
        y_d = prod_w;
        ma = 25'($signed(t_q[43:20]));
        mb = x;
        state_d = S_S6;
      end
      S_S6: begin
        y_d = y_q + (prod_w <<< 20);
        ma = $signed({5'b0, acc_q[19:0]});
        mb = run;
        state_d = S_S7;
      end
      S_S7: begin
        y_d = y_q + prod_w;
        ma = 25'($signed(acc_q[43:20]));
        mb = run;
        state_d = S_S8;
      end
      S_S8: begin
        acc_d = y_q + (prod_w <<< 20);
        ma = $signed({8'b0, q_q});
        mb = run;
        state_d = S_S9;
      end
      S_S9: begin
        den_d = {prod_q[DEN_W-2:0], 1'b0};
        state_d = S_DS;
      end
      S_DS: begin
        div_start = 1'b1;
        state_d = S_DW;
      end
      S_DW: begin
        if (div_done) begin
          if (req_q == REQ_INTERP) begin
            res_d = sat16(NUM_W'(vl_q) + NUM_W'(quot));
          end else begin
            res_d = sat16(NUM_W'(quot));
          end
          st_d = ST_VALID;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the result register to free up
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          m_user_d  = st_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= CFG_W'(1);
      m_valid_q <= 1'b0;
      i_q       <= '0;
      n_q       <= KF_CNT_W'(1);
      req_q     <= REQ_LOAD;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      i_q       <= i_d;
      n_q       <= n_d;
      req_q     <= req_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    pl_q     <= pl_d;
    vl_q     <= vl_d;
    pc_q     <= pc_d;
    vc_q     <= vc_d;
    acc_q    <= acc_d;
    t_q      <= t_d;
    y_q      <= y_d;
    den_q    <= den_d;
    res_q    <= res_d;
    st_q     <= st_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    prod_q   <= ma * mb;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DW))
    else $error("divider done outside wait state");

  // a load transfer goes straight to the result stage
  a_load_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == REQ_LOAD) |=> (state_q == S_OUT))
    else $error("load did not complete directly");

  // average walk never steps past the keyframe count
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AW) |-> (i_q <= n_q && i_q != '0))
    else $error("walk index out of range");

  // rejected requests carry a zero value
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_REJECT) |-> (m_axis_tdata == '0))
    else $error("reject with nonzero value");

endmodule

// ===== tb/keyframe_envelope_interpolator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_envelope_interpolator_tb: self-checking bench for the envelope block
// Loads keyframe tables and fires interpolate, average and unknown-code
// requests. A local envelope predictor supplies the expected value and status,
// and every result transfer is compared in order. Random idling is applied.
// ----------------------------------------------------------------------------
module keyframe_envelope_interpolator_tb;
  import kfi_pkg::*;

  // request code with no meaning, always rejected
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  idx;
    logic [16:0] kpos;
    logic [15:0] kval;
    logic [16:0] qpos;
  } env_req_t;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  status;
  } env_res_t;

  // directed row: a request plus an optional typed-in answer
  typedef struct {
    env_req_t rq;
    bit       fixed;
    env_res_t res;
  } env_row_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  keyframe_envelope_interpolator DUT (.*);

  // predictor state
  logic [16:0]        kf_pos[MAX_KEYFRAMES];
  logic signed [15:0] kf_lvl[MAX_KEYFRAMES];
  logic [4:0]         kf_count;

  env_res_t pending_results[$];
  int       mismatch_cnt;
  int       send_idle_pct, recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp_pos(logic [16:0] p);
    return (p > 17'd65536) ? 65536 : longint'(p);
  endfunction

  function automatic logic [15:0] clamp_level(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int active_keys();
    if (kf_count == 0) return 1;
    if (kf_count > MAX_KEYFRAMES) return MAX_KEYFRAMES;
    return kf_count;
  endfunction

  function automatic logic [15:0] envelope_at(longint q, int n);
    int i;
    longint pl, pr, vl, vr;
    if (n == 1 || q <= kf_pos[0]) return kf_lvl[0];
    if (q >= kf_pos[n-1]) return kf_lvl[n-1];
    i = 1;
    while (i < n - 1 && q >= kf_pos[i]) i++;
    pl = kf_pos[i-1]; pr = kf_pos[i];
    vl = kf_lvl[i-1]; vr = kf_lvl[i];
    return clamp_level(vl + (q - pl) * (vr - vl) / (pr - pl));
  endfunction

  function automatic logic [15:0] envelope_mean(longint q, int n);
    int i;
    longint acc, num, den, pl, run, x, vl, dv;
    if (q <= kf_pos[0]) return kf_lvl[0];
    acc = 2 * longint'(kf_lvl[0]) * longint'(kf_pos[0]);
    i = 1;
    while (i < n && kf_pos[i] < q) begin
      acc += (longint'(kf_pos[i]) - longint'(kf_pos[i-1])) *
             (longint'(kf_lvl[i]) + longint'(kf_lvl[i-1]));
      i++;
    end
    if (i < n) begin
      pl  = kf_pos[i-1];
      run = longint'(kf_pos[i]) - pl;
      x   = q - pl;
      vl  = kf_lvl[i-1];
      dv  = longint'(kf_lvl[i]) - vl;
      num = acc * run + x * (2 * vl * run + x * dv);
      den = 2 * q * run;
    end else begin
      acc += 2 * (q - longint'(kf_pos[n-1])) * longint'(kf_lvl[n-1]);
      num = acc;
      den = 2 * q;
    end
    return clamp_level(num / den);
  endfunction

  // updates the table on loads and returns the expected answer
  function automatic env_res_t predict_envelope(env_req_t rq);
    env_res_t r;
    int n;
    n = active_keys();
    r = '{value: '0, status: ST_REJECT};
    case (rq.req)
      REQ_LOAD: begin
        kf_pos[rq.idx] = 17'(clamp_pos(rq.kpos));
        kf_lvl[rq.idx] = rq.kval;
        r.status = ST_STORED;
      end
      REQ_INTERP: begin
        r.value  = envelope_at(clamp_pos(rq.qpos), n);
        r.status = ST_VALID;
      end
      REQ_AVG: begin
        if (n >= 2) begin
          r.value  = envelope_mean(clamp_pos(rq.qpos), n);
          r.status = ST_VALID;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk_i) begin
    env_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result %h/%0d", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (want.value !== m_axis_tdata || want.status !== m_axis_tuser) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     want.value, want.status, m_axis_tdata, m_axis_tuser);
        end
      end
    end
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      m_axis_tready <= 1'b0;
    end
  end

  // one request transfer; expectation recorded when accepted
  task automatic send_request(env_req_t rq, bit fixed = 0, env_res_t res = '0);
    env_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b0, rq.qpos, rq.kval, rq.kpos, rq.idx};
    s_axis_tuser  <= rq.req;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_envelope(rq);
    if (fixed) r = res;
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_count(logic [4:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    kf_count  = v;
  endtask

  function automatic env_req_t make_req(logic [1:0] t, logic [3:0] i, logic [16:0] kp,
                                        logic [15:0] kv, logic [16:0] q);
    return '{req: t, idx: i, kpos: kp, kval: kv, qpos: q};
  endfunction

  // random query, mostly in range, some above 1.0
  function automatic logic [16:0] rand_pos();
    if ($urandom_range(9) == 0) return 17'($urandom_range(131071));
    return 17'($urandom_range(65536));
  endfunction

  // load a sorted table of n entries with random levels
  task automatic load_sorted_table(int n);
    logic [16:0] p;
    p = 17'($urandom_range(3) == 0 ? 0 : $urandom_range(4000));
    for (int i = 0; i < n; i++) begin
      send_request(make_req(REQ_LOAD, 4'(i), p, 16'($urandom), '0));
      p = 17'(clamp_pos(longint'(p) + $urandom_range(1, 65536 / n)));
    end
  endtask

  env_row_t directed_rows[$];
  logic [4:0] cnt_choices[] = '{5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd31, 5'd0, 5'd1, 5'd4};
  int total;

  initial begin
    env_row_t row;
    int n;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    mismatch_cnt = 0; kf_count = 5'd1;
    send_idle_pct = 6; recv_idle_pct = 76;
    for (int i = 0; i < MAX_KEYFRAMES; i++) begin
      kf_pos[i] = '0; kf_lvl[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: extremes, each request, rejects, saturation
    directed_rows = '{
      '{make_req(REQ_LOAD, 4'd0, 17'd0, 16'h8000, '0), 1, '{16'h0, ST_STORED}},
      '{make_req(REQ_UNKNOWN, 4'd0, '0, '0, '0), 1, '{16'h0, ST_REJECT}},
      '{make_req(REQ_AVG, 4'd0, '0, '0, 17'd100), 1, '{16'h0, ST_REJECT}},
      '{make_req(REQ_INTERP, 4'd0, '0, '0, 17'h1FFFF), 1, '{16'h8000, ST_VALID}},
      '{make_req(REQ_LOAD, 4'd15, 17'h1FFFF, 16'h7FFF, '0), 1, '{16'h0, ST_STORED}},
      '{make_req(REQ_LOAD, 4'd0, 17'd16384, 16'h7FFF, '0), 0, '0},
      '{make_req(REQ_LOAD, 4'd1, 17'd49152, 16'h8000, '0), 0, '0},
      '{make_req(REQ_LOAD, 4'd2, 17'd65536, 16'h0100, '0), 0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.rq, row.fixed, row.res);
    end
    write_count(5'd3);
    directed_rows = '{
      '{make_req(REQ_INTERP, '0, '0, '0, 17'd0), 1, '{16'h7FFF, ST_VALID}},
      '{make_req(REQ_INTERP, '0, '0, '0, 17'd32768), 0, '0},
      '{make_req(REQ_INTERP, '0, '0, '0, 17'd65536), 1, '{16'h0100, ST_VALID}},
      '{make_req(REQ_INTERP, '0, '0, '0, 17'h1FFFF), 1, '{16'h0100, ST_VALID}},
      '{make_req(REQ_AVG, '0, '0, '0, 17'd0), 1, '{16'h7FFF, ST_VALID}},
      '{make_req(REQ_AVG, '0, '0, '0, 17'd16384), 1, '{16'h7FFF, ST_VALID}},
      '{make_req(REQ_AVG, '0, '0, '0, 17'd40000), 0, '0},
      '{make_req(REQ_AVG, '0, '0, '0, 17'd65536), 0, '0},
      '{make_req(REQ_AVG, '0, '0, '0, 17'h1FFFF), 0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.rq, row.fixed, row.res);
    end

    // random phases: a table of some size, then queries and occasional noise
    total = 0;
    for (int ph = 0; total < 1500; ph++) begin
      if (total > 500 && total <= 1000) begin
        send_idle_pct = 76; recv_idle_pct = 6;
      end else if (total > 1000) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_count(cnt_choices[ph % cnt_choices.size()]);
      n = active_keys();
      load_sorted_table(n);
      total += n;
      repeat (40) begin
        case ($urandom_range(9))
          0: send_request(make_req(REQ_LOAD, 4'($urandom_range(n - 1)), rand_pos(),
                                   16'($urandom), '0));
          1: send_request(make_req(REQ_UNKNOWN, 4'($urandom), 17'($urandom),
                                   16'($urandom), 17'($urandom)));
          2, 3, 4, 5: send_request(make_req(REQ_INTERP, 4'($urandom), 17'($urandom),
                                            16'($urandom), rand_pos()));
          default: send_request(make_req(REQ_AVG, 4'($urandom), 17'($urandom),
                                         16'($urandom), rand_pos()));
        endcase
        total++;
      end
      // sender waits for the block to empty once in a while
      if (ph % 5 == 2) drain_results();
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
